FILE: rtl/assert_macros.svh
// assertion macros used by the position parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock outside reset
`define ASSERT_ALWAYS(name, ck, rn, cond) \
	name: assert property (@(posedge ck) disable iff (!(rn)) (cond)) \
		else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(name, ck, rn, pre, post) \
	name: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, ck, rn, pre, post) \
	name: assert property (@(posedge ck) disable iff (!(rn)) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

FILE: rtl/ngga_pkg.sv
// types, character codes and constants of the gga position parser
package ngga_pkg;

	// character codes
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_S     = 8'h53;
	localparam logic [7:0] CHAR_W     = 8'h57;

	// field numbers counted by commas from the line start
	localparam logic [2:0] FIELD_START   = 3'd0;
	localparam logic [2:0] FIELD_LAT     = 3'd2;
	localparam logic [2:0] FIELD_LAT_HEM = 3'd3;
	localparam logic [2:0] FIELD_LON     = 3'd4;
	localparam logic [2:0] FIELD_LON_HEM = 3'd5;
	localparam logic [2:0] FIELD_DONE    = 3'd6;

	// degree digit counts at the head of each coordinate field
	localparam logic [3:0] LAT_DEGREE_DIGITS = 4'd2;
	localparam logic [3:0] LON_DEGREE_DIGITS = 4'd3;
	localparam logic [3:0] CHARS_MAX         = 4'd15;

	// payload widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LAT_W  = 31;
	localparam int unsigned LON_W  = 32;

	// scaling and limits, 1e-7 degree units
	localparam logic [30:0] SCALE_31   = 31'd10000000;
	localparam logic [31:0] SCALE_32   = 32'd10000000;
	localparam logic [32:0] LAT_MAX    = 33'd900000000;
	localparam logic [32:0] LON_MAX    = 33'd1800000000;
	localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;
	localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;

	// floor(2^32 / 15), quotient estimate is low by at most one
	localparam logic [28:0] RECIP_15 = 29'd286331153;
	localparam logic [28:0] FIFTEEN  = 29'd15;
	localparam logic [2:0]  POW_IDX_MAX = 3'd7;

	// powers of ten up to ten million
	localparam logic [23:0] POW10_TABLE [8] = '{
		24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000,
		24'd1000000, 24'd10000000
	};

	// accumulator snapshot taken at the comma closing a hemisphere field
	typedef struct packed {
		logic       is_lon;
		logic       neg;
		logic [7:0] degree;
		logic [6:0] minute_whole;
	} ngga_job_t;

	// finished signed coordinate leaving the arithmetic pipeline
	typedef struct packed {
		logic               is_lon;
		logic signed [31:0] value;
	} ngga_coord_t;

	// elaboration-time power of ten
	function automatic int unsigned pow10_of(input int unsigned n);
		int unsigned v;
		v = 1;
		for (int unsigned i = 0; i < n; i++) begin
			v = v * 10;
		end
		return v;
	endfunction

endpackage

FILE: rtl/ngga_byte_if.sv
// character channel carrying one byte of the response line per request
interface ngga_byte_if;
	import ngga_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

FILE: rtl/ngga_pos_if.sv
// position channel carrying one latitude and longitude pair per request
interface ngga_pos_if;
	import ngga_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [LAT_W-1:0] latitude;
	logic signed [LON_W-1:0] longitude;

	modport source(output valid, output latitude, output longitude, input ready);
	modport sink(input valid, input latitude, input longitude, output ready);
endinterface

FILE: rtl/ngga_coord.sv
// three-stage pipeline turning degree and minute sums into signed 1e-7 degrees
module ngga_coord #(
	parameter int unsigned MINUTE_FRACTION_DIGITS = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  ngga_pkg::ngga_job_t     push_job,
	input  logic [$clog2(ngga_pkg::pow10_of(MINUTE_FRACTION_DIGITS))-1:0] push_frac,
	input  logic [$clog2(MINUTE_FRACTION_DIGITS+1)-1:0]                   push_seen,
	output logic                    res_valid,
	input  logic                    res_ready,
	output ngga_pkg::ngga_coord_t   res
);
	import ngga_pkg::*;

	localparam int unsigned FRAC_W = $clog2(pow10_of(MINUTE_FRACTION_DIGITS));
	localparam int unsigned SEEN_W = $clog2(MINUTE_FRACTION_DIGITS + 1);

	// stage registers
	logic              valid_s1, valid_s2, valid_s3;
	ngga_job_t         job_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic [SEEN_W-1:0] seen_s1;
	logic [28:0]       x_s2, x_s3;
	logic [31:0]       deg_s2, deg_s3;
	logic              neg_s2, neg_s3, lon_s2, lon_s3;
	logic [24:0]       q_s3;

	logic ready2, ready3;

	// stage 1 arithmetic
	logic [2:0]         pow_idx;
	logic [23:0]        pow_sel;
	logic [FRAC_W+23:0] frac_prod;
	logic [30:0]        whole_term;
	logic [30:0]        minute_n;
	logic [31:0]        deg_term;

	// stage 2 arithmetic
	logic [57:0] recip_prod;

	// stage 3 arithmetic
	logic [28:0] q_times_15;
	logic [28:0] rem;
	logic [24:0] q_fix;
	logic [32:0] mag_raw;
	logic [32:0] mag_lim;
	logic [32:0] mag_clip;
	logic [31:0] mag32;

	// backward ready chain
	assign ready3     = !valid_s3 || res_ready;
	assign ready2     = !valid_s2 || ready3;
	assign push_ready = !valid_s1 || ready2;

	// minutes scaled to 1e-7 minute and degrees scaled to 1e-7 degree
	always_comb begin
		pow_idx    = POW_IDX_MAX - 3'(seen_s1);
		pow_sel    = POW10_TABLE[pow_idx];
		frac_prod  = (FRAC_W+24)'(frac_s1) * (FRAC_W+24)'(pow_sel);
		whole_term = 31'(job_s1.minute_whole) * SCALE_31;
		minute_n   = whole_term + 31'(frac_prod[23:0]);
		deg_term   = 32'(job_s1.degree) * SCALE_32;
	end

	// x_s2 holds the minute sum divided by four; divide by fifteen through a reciprocal
	assign recip_prod = 58'(x_s2) * 58'(RECIP_15);

	// quotient correction, degree add, clipping and sign
	always_comb begin
		q_times_15 = {q_s3, 4'b0000} - {4'b0000, q_s3};
		rem        = x_s3 - q_times_15;
		q_fix      = q_s3 + 25'(rem >= FIFTEEN);
		mag_raw    = {1'b0, deg_s3} + 33'(q_fix);
		mag_lim    = lon_s3 ? LON_MAX : LAT_MAX;
		mag_clip   = (mag_raw > mag_lim) ? mag_lim : mag_raw;
		mag32      = {1'b0, mag_clip[30:0]};
		res.is_lon = lon_s3;
		res.value  = neg_s3 ? $signed(32'd0 - mag32) : $signed(mag32);
	end

	assign res_valid = valid_s3;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (push_ready) valid_s1 <= push_valid;
			if (ready2)     valid_s2 <= valid_s1;
			if (ready3)     valid_s3 <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (push_ready && push_valid) begin
			job_s1  <= push_job;
			frac_s1 <= push_frac;
			seen_s1 <= push_seen;
		end
		if (ready2 && valid_s1) begin
			x_s2   <= minute_n[30:2];
			deg_s2 <= deg_term;
			neg_s2 <= job_s1.neg;
			lon_s2 <= job_s1.is_lon;
		end
		if (ready3 && valid_s2) begin
			q_s3   <= recip_prod[56:32];
			x_s3   <= x_s2;
			deg_s3 <= deg_s2;
			neg_s3 <= neg_s2;
			lon_s3 <= lon_s2;
		end
	end

endmodule

FILE: rtl/nmea_gga_position_parser.sv
// GGA position parser: comma-counting front end, output register and checks
//
// Usage: feed the GGA response line one ASCII character per request on the
// chars channel. Commas are counted from the line start; CR or LF restarts
// the count. Field 2 and 3 give latitude and its hemisphere, field 4 and 5
// longitude and its hemisphere. At the comma that closes field 5 one request
// leaves on the position channel: signed latitude and longitude in 1e-7
// degree, south and west negative, rounded toward zero.
// Throughput: one character per cycle while chars.ready is high; it drops
// when the arithmetic stages back up. The snapshot taken at the closing comma
// passes the three arithmetic stages (minute scaling and degree multiply,
// reciprocal multiply by 1/15, correction and clipping) to the output register.
// Reset clears the field count, the accumulators, the held latitude and all
// stage valid flags; no clearing pass is needed.
// Stall: a finished position waits in the output register while characters
// keep flowing; up to three further coordinates queue in the stages before
// chars.ready drops.
`include "assert_macros.svh"

module nmea_gga_position_parser #(
	parameter int unsigned MINUTE_FRACTION_DIGITS = 5
) (
	input logic         clk,
	input logic         arst_n,
	ngga_byte_if.sink   chars,
	ngga_pos_if.source  position
);
	import ngga_pkg::*;

	localparam int unsigned FRAC_W = $clog2(pow10_of(MINUTE_FRACTION_DIGITS));
	localparam int unsigned SEEN_W = $clog2(MINUTE_FRACTION_DIGITS + 1);

	// parser state
	logic [2:0]        field_q, field_d;
	logic [3:0]        chars_q, chars_d;
	logic [7:0]        deg_q, deg_d;
	logic [6:0]        whole_q, whole_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic [SEEN_W-1:0] seen_q, seen_d;
	logic              point_q, point_d;
	logic              neg_q, neg_d;

	// latitude hold and output register
	logic signed [LAT_W-1:0] lat_hold_q;
	logic                    out_valid_q;
	logic signed [LAT_W-1:0] lat_q;
	logic signed [LON_W-1:0] lon_q;

	logic        accept;
	logic [7:0]  b;
	logic        is_eol, is_comma, is_digit;
	logic [3:0]  digit;
	logic [3:0]  deg_digits;
	logic [11:0] deg_mul;
	logic [10:0] whole_mul;
	logic [2:0]  field_inc;

	logic        push_valid, push_ready;
	ngga_job_t   push_job;
	logic        res_valid, res_ready;
	ngga_coord_t res;
	logic        out_load;

	assign b        = chars.data_byte;
	assign accept   = chars.valid && chars.ready;
	assign is_eol   = (b == CHAR_CR) || (b == CHAR_LF);
	assign is_comma = (b == CHAR_COMMA);
	assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	assign digit    = is_digit ? 4'(b - CHAR_ZERO) : 4'd0;

	// next parser state for one character
	always_comb begin
		field_d    = field_q;
		chars_d    = chars_q;
		deg_d      = deg_q;
		whole_d    = whole_q;
		frac_d     = frac_q;
		seen_d     = seen_q;
		point_d    = point_q;
		neg_d      = neg_q;
		deg_digits = (field_q == FIELD_LAT) ? LAT_DEGREE_DIGITS : LON_DEGREE_DIGITS;
		deg_mul    = 12'(deg_q) * 12'd10 + 12'(digit);
		whole_mul  = 11'(whole_q) * 11'd10 + 11'(digit);
		field_inc  = (field_q < FIELD_DONE) ? field_q + 3'd1 : field_q;
		if (is_eol) begin
			field_d = FIELD_START;
			chars_d = 4'd0;
			deg_d   = '0;
			whole_d = '0;
			frac_d  = '0;
			seen_d  = '0;
			point_d = 1'b0;
			neg_d   = 1'b0;
		end else if (is_comma) begin
			field_d = field_inc;
			chars_d = 4'd0;
			if (field_inc == FIELD_LAT || field_inc == FIELD_LON) begin
				deg_d   = '0;
				whole_d = '0;
				frac_d  = '0;
				seen_d  = '0;
				point_d = 1'b0;
				neg_d   = 1'b0;
			end
			if (field_inc == FIELD_LAT_HEM || field_inc == FIELD_LON_HEM) begin
				neg_d = 1'b0;
			end
		end else begin
			if (field_q == FIELD_LAT || field_q == FIELD_LON) begin
				// degree digits, then whole minutes, then fraction digits
				if (chars_q < deg_digits) begin
					deg_d = (deg_mul > 12'd255) ? 8'hFF : deg_mul[7:0];
				end else if (point_q) begin
					if (seen_q < SEEN_W'(MINUTE_FRACTION_DIGITS)) begin
						frac_d = frac_q * FRAC_W'(10) + FRAC_W'(digit);
						seen_d = seen_q + SEEN_W'(1);
					end
				end else if (b == CHAR_POINT) begin
					point_d = 1'b1;
				end else begin
					whole_d = (whole_mul > 11'd127) ? 7'h7F : whole_mul[6:0];
				end
			end else if (field_q == FIELD_LAT_HEM) begin
				neg_d = (chars_q == 4'd0) && (b == CHAR_S);
			end else if (field_q == FIELD_LON_HEM) begin
				neg_d = (chars_q == 4'd0) && (b == CHAR_W);
			end
			if (chars_q < CHARS_MAX) chars_d = chars_q + 4'd1;
		end
	end

	// snapshot for the arithmetic stages at a closing hemisphere comma
	assign push_valid = chars.valid && is_comma &&
		(field_q == FIELD_LAT_HEM || field_q == FIELD_LON_HEM);
	always_comb begin
		push_job.is_lon       = (field_q == FIELD_LON_HEM);
		push_job.neg          = neg_q;
		push_job.degree       = deg_q;
		push_job.minute_whole = whole_q;
	end
	assign chars.ready = push_ready;

	ngga_coord #(
		.MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
	) u_coord (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.push_frac  (frac_q),
		.push_seen  (seen_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// latitude goes to the hold register, longitude needs the output register
	assign out_load  = !out_valid_q || position.ready;
	assign res_ready = !res.is_lon || out_load;

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= FIELD_START;
			chars_q <= 4'd0;
			deg_q   <= '0;
			whole_q <= '0;
			frac_q  <= '0;
			seen_q  <= '0;
			point_q <= 1'b0;
			neg_q   <= 1'b0;
		end else if (accept) begin
			field_q <= field_d;
			chars_q <= chars_d;
			deg_q   <= deg_d;
			whole_q <= whole_d;
			frac_q  <= frac_d;
			seen_q  <= seen_d;
			point_q <= point_d;
			neg_q   <= neg_d;
		end
	end

	// held latitude and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_hold_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid && !res.is_lon) lat_hold_q <= res.value[LAT_W-1:0];
			if (out_load) out_valid_q <= res_valid && res.is_lon;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load && res_valid && res.is_lon) begin
			lat_q <= lat_hold_q;
			lon_q <= res.value;
		end
	end

	assign position.valid     = out_valid_q;
	assign position.latitude  = lat_q;
	assign position.longitude = lon_q;

	// checks
	`ASSERT_NEXT(a_eol_restarts, clk, arst_n, accept && is_eol, field_q == FIELD_START && chars_q == 4'd0)
	`ASSERT_ALWAYS(a_field_bounded, clk, arst_n, field_q <= FIELD_DONE)
	`ASSERT_IMPLIES(a_lon_in_range, clk, arst_n, out_valid_q, lon_q <= LON_LIMIT && lon_q >= -LON_LIMIT)
	`ASSERT_IMPLIES(a_lat_in_range, clk, arst_n, out_valid_q, lat_q <= LAT_LIMIT && lat_q >= -LAT_LIMIT)

endmodule

FILE: tb/sv/nmea_gga_position_parser_test.sv
// testbench of the gga position parser: directed and random response lines, predicted positions
`timescale 1ns / 100ps

module nmea_gga_position_parser_test;
	import ngga_pkg::*;

	localparam int unsigned FRAC_DIGITS  = 5;
	localparam longint unsigned DEG_UNIT = 64'd10000000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned RANDOM_CHARS = 400;

	typedef struct packed {
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
	} fix_t;

	logic clk;
	logic arst_n;

	ngga_byte_if char_link();
	ngga_pos_if  pos_link();

	nmea_gga_position_parser #(
		.MINUTE_FRACTION_DIGITS(FRAC_DIGITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(char_link),
		.position(pos_link)
	);

	// parser state as the testbench tracks it
	logic [2:0]  fld_no;
	logic [3:0]  fld_chars;
	logic [7:0]  deg_acc;
	logic [6:0]  min_whole_acc;
	logic [31:0] min_frac_acc;
	logic [2:0]  frac_count;
	logic        after_point;
	logic        south_or_west;
	logic [LAT_W-1:0] held_latitude;

	fix_t expected_fixes[$];
	logic [7:0] line_chars[$];

	int unsigned mismatches      = 0;
	int unsigned chars_sent      = 0;
	bit sender_gaps     = 1'b1;
	bit receiver_stalls = 1'b1;
	bit long_stalls     = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("FAIL nmea_gga_position_parser");
		$finish;
	end

	// idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(3, 1);
		else if (roll < 97)
			return $urandom_range(10, 4);
		else
			return $urandom_range(40, 11);
	endfunction

	task automatic clear_sums();
		deg_acc       = '0;
		min_whole_acc = '0;
		min_frac_acc  = '0;
		frac_count    = '0;
		after_point   = 1'b0;
		south_or_west = 1'b0;
	endtask

	// signed coordinate in 1e-7 degree, magnitude truncated and clipped
	function automatic logic [31:0] degrees_e7(input logic [63:0] limit);
		logic [63:0] unit_pow, frac_pow, minutes, mag;
		unit_pow = 64'd1;
		frac_pow = 64'd1;
		for (int i = 0; i < FRAC_DIGITS; i++)
			unit_pow = unit_pow * 10;
		for (int i = frac_count; i < FRAC_DIGITS; i++)
			frac_pow = frac_pow * 10;
		minutes = 64'(min_whole_acc) * unit_pow + 64'(min_frac_acc) * frac_pow;
		mag = 64'(deg_acc) * DEG_UNIT + (minutes * DEG_UNIT) / (64'd60 * unit_pow);
		if (mag > limit)
			mag = limit;
		if (south_or_west)
			mag = 64'd0 - mag;
		return mag[31:0];
	endfunction

	// one character of a coordinate field
	task automatic accumulate_digit(input logic [7:0] c, input logic [3:0] deg_digits);
		int unsigned d, v;
		d = (c >= CHAR_ZERO && c <= CHAR_NINE) ? 32'(c - CHAR_ZERO) : 0;
		if (fld_chars < deg_digits) begin
			v = deg_acc * 10 + d;
			deg_acc = (v > 255) ? 8'd255 : v[7:0];
		end else if (after_point) begin
			if (frac_count < FRAC_DIGITS) begin
				min_frac_acc = min_frac_acc * 10 + d;
				frac_count = frac_count + 3'd1;
			end
		end else if (c == CHAR_POINT) begin
			after_point = 1'b1;
		end else begin
			v = min_whole_acc * 10 + d;
			min_whole_acc = (v > 127) ? 7'd127 : v[6:0];
		end
	endtask

	// advance the tracked state by one accepted character
	task automatic absorb_char(input logic [7:0] c);
		logic [31:0] coord;
		fix_t fix;
		if (c == CHAR_CR || c == CHAR_LF) begin
			fld_no = FIELD_START;
			fld_chars = '0;
			clear_sums();
		end else if (c == CHAR_COMMA) begin
			if (fld_no == FIELD_LAT_HEM) begin
				coord = degrees_e7(LAT_MAX);
				held_latitude = coord[LAT_W-1:0];
			end
			if (fld_no == FIELD_LON_HEM) begin
				fix.lat = held_latitude;
				fix.lon = degrees_e7(LON_MAX);
				expected_fixes.push_back(fix);
			end
			if (fld_no < FIELD_DONE)
				fld_no = fld_no + 3'd1;
			fld_chars = '0;
			if (fld_no == FIELD_LAT || fld_no == FIELD_LON)
				clear_sums();
			if (fld_no == FIELD_LAT_HEM || fld_no == FIELD_LON_HEM)
				south_or_west = 1'b0;
		end else begin
			if (fld_no == FIELD_LAT)
				accumulate_digit(c, LAT_DEGREE_DIGITS);
			else if (fld_no == FIELD_LON)
				accumulate_digit(c, LON_DEGREE_DIGITS);
			else if (fld_no == FIELD_LAT_HEM)
				south_or_west = (fld_chars == 0 && c == CHAR_S);
			else if (fld_no == FIELD_LON_HEM)
				south_or_west = (fld_chars == 0 && c == CHAR_W);
			if (fld_chars < CHARS_MAX)
				fld_chars = fld_chars + 4'd1;
		end
	endtask

	// check positions first, then track the character taken at the same edge
	always @(posedge clk) begin
		fix_t want;
		if (!arst_n) begin
			fld_no = FIELD_START;
			fld_chars = '0;
			clear_sums();
			held_latitude = '0;
		end else begin
			if (pos_link.valid && pos_link.ready) begin
				if (expected_fixes.size() == 0) begin
					$display("%0t: unexpected position: lat %0d lon %0d", $time,
						pos_link.latitude, pos_link.longitude);
					mismatches++;
				end else begin
					want = expected_fixes.pop_front();
					if (pos_link.latitude !== want.lat) begin
						$display("%0t: latitude expected %0d, got %0d", $time,
							want.lat, pos_link.latitude);
						mismatches++;
					end
					if (pos_link.longitude !== want.lon) begin
						$display("%0t: longitude expected %0d, got %0d", $time,
							want.lon, pos_link.longitude);
						mismatches++;
					end
				end
			end
			if (char_link.valid && char_link.ready)
				absorb_char(char_link.data_byte);
		end
	end

	// position receiver with random stalls
	initial begin
		int unsigned stall;
		pos_link.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_stalls)
				stall = $urandom_range(60, 30);
			else
				stall = receiver_stalls ? pick_gap() : 0;
			if (stall != 0) begin
				pos_link.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pos_link.ready <= 1'b1;
			repeat ($urandom_range(6, 1) - 1) @(posedge clk);
		end
	end

	// one character request, held until taken
	task automatic send_char(input logic [7:0] c);
		int unsigned gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap != 0) begin
			char_link.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_link.valid <= 1'b1;
		char_link.data_byte <= c;
		do
			@(posedge clk);
		while (!char_link.ready);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_line();
		foreach (line_chars[i])
			send_char(line_chars[i]);
	endtask

	// hold off the sender until every predicted position has come out
	task automatic wait_drained();
		char_link.valid <= 1'b0;
		@(posedge clk);
		while (expected_fixes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// line builders for the random part
	task automatic add_digits(input int unsigned n);
		repeat (n) line_chars.push_back(CHAR_ZERO + 8'($urandom_range(9, 0)));
	endtask

	task automatic add_junk(input int unsigned n);
		logic [7:0] c;
		repeat (n) begin
			c = 8'($urandom_range(126, 32));
			line_chars.push_back(c == CHAR_COMMA ? CHAR_S : c);
		end
	endtask

	task automatic add_coordinate(input int unsigned deg_digits);
		int unsigned roll, pick;
		roll = $urandom_range(99, 0);
		if (roll < 5) begin
			// empty field
		end else if (roll < 15) begin
			// loose mix of digits, points and other characters
			repeat ($urandom_range(14, 1)) begin
				pick = $urandom_range(9, 0);
				if (pick < 6)
					add_digits(1);
				else if (pick < 8)
					line_chars.push_back(CHAR_POINT);
				else
					add_junk(1);
			end
		end else begin
			add_digits(deg_digits + 2);
			if (roll < 92) begin
				line_chars.push_back(CHAR_POINT);
				add_digits($urandom_range(8, 0));
			end
			if (roll >= 96)
				add_junk(1);
		end
	endtask

	task automatic add_hemisphere(input logic [7:0] neg_char, input logic [7:0] pos_char);
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 45)
			line_chars.push_back(neg_char);
		else if (roll < 90)
			line_chars.push_back(pos_char);
		else if (roll < 95) begin
			// empty field
		end else begin
			line_chars.push_back(neg_char);
			add_junk($urandom_range(2, 1));
		end
	endtask

	task automatic build_sentence();
		add_junk($urandom_range(6, 0));
		line_chars.push_back(CHAR_COMMA);
		add_digits($urandom_range(6, 0));
		line_chars.push_back(CHAR_COMMA);
		add_coordinate(LAT_DEGREE_DIGITS);
		line_chars.push_back(CHAR_COMMA);
		add_hemisphere(CHAR_S, "N");
		line_chars.push_back(CHAR_COMMA);
		add_coordinate(LON_DEGREE_DIGITS);
		line_chars.push_back(CHAR_COMMA);
		add_hemisphere(CHAR_W, "E");
		line_chars.push_back(CHAR_COMMA);
		repeat ($urandom_range(3, 0)) begin
			add_digits($urandom_range(3, 0));
			line_chars.push_back(CHAR_COMMA);
		end
	endtask

	task automatic add_line_end();
		int unsigned roll;
		roll = $urandom_range(2, 0);
		if (roll != 2)
			line_chars.push_back(CHAR_CR);
		if (roll != 1)
			line_chars.push_back(CHAR_LF);
	endtask

	// ordinary north/east and south/west lines
	task automatic test_plain_positions();
		send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
		send_char(CHAR_CR);
		send_char(CHAR_LF);
		send_text(",,3352.12345,S,15112.54321,W,");
		send_char(CHAR_LF);
	endtask

	// clipping, zero, values just under the limits, bytes with all bits set and clear
	task automatic test_extreme_values();
		send_text(",,9999.99999,S,99999.99999,W,");
		send_char(CHAR_LF);
		send_text(",,0000.00000,N,00000.00000,E,");
		send_char(CHAR_LF);
		send_text(",,8959.99999,N,17959.99999,E,");
		send_char(CHAR_LF);
		send_text(",,");
		send_char(8'hFF);
		send_char(8'h00);
		send_char(8'h80);
		send_char(8'h7F);
		send_text(",S,1,W,");
		send_char(CHAR_LF);
	endtask

	// points in degree places, non-digits, long hemisphere fields, saturation
	task automatic test_odd_fields();
		send_text(",,4.7.5X,SS,1.2..34,W,");
		send_char(CHAR_LF);
		send_text(",,12999.123456789,s,123456.9,,");
		send_char(CHAR_LF);
		send_text(",,12345678901234567890,SSSSSSSSSSSSSSSS,1,W,");
		send_char(CHAR_LF);
	endtask

	// missing sixth comma, restart inside a field, fields beyond six
	task automatic test_line_breaks();
		send_text(",,4916.45,S,12311.12,W");
		send_char(CHAR_CR);
		send_text(",,12");
		send_char(CHAR_CR);
		send_text(",,5000.0,S,00100.0,W,,,,,,,,,,");
		send_char(CHAR_LF);
		send_text(",,1,S");
		send_char(CHAR_LF);
		send_text(",,2,N,3,E,");
		send_char(CHAR_LF);
	endtask

	// short lines back to back while the receiver stalls for long stretches
	task automatic test_back_pressure();
		sender_gaps = 1'b0;
		long_stalls = 1'b1;
		repeat (12) begin
			send_text(",,1,S,2,W,");
			send_char(CHAR_LF);
		end
		long_stalls = 1'b0;
		sender_gaps = 1'b1;
		wait_drained();
	endtask

	// mostly well-formed random lines, some cut short, some noise
	task automatic test_random_lines();
		int unsigned first_char, lines, roll, cut;
		first_char = chars_sent;
		lines = 0;
		while ((chars_sent - first_char) < RANDOM_CHARS) begin
			if (lines % 8 == 0) begin
				sender_gaps     = ($urandom_range(3, 0) != 0);
				receiver_stalls = ($urandom_range(3, 0) != 0);
			end
			if (lines == 5)
				wait_drained();
			line_chars = {};
			roll = $urandom_range(99, 0);
			if (roll < 80) begin
				build_sentence();
			end else if (roll < 90) begin
				build_sentence();
				cut = $urandom_range(line_chars.size() - 1, 0);
				while (line_chars.size() > cut)
					void'(line_chars.pop_back());
			end else begin
				repeat ($urandom_range(20, 1))
					line_chars.push_back(8'($urandom_range(255, 0)));
			end
			add_line_end();
			send_line();
			lines++;
		end
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	// reset, tests in turn, verdict
	initial begin
		arst_n <= 1'b0;
		char_link.valid <= 1'b0;
		char_link.data_byte <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_positions();
		test_extreme_values();
		test_odd_fields();
		test_line_breaks();
		wait_drained();
		test_back_pressure();
		test_random_lines();
		wait_drained();
		if (mismatches == 0)
			$display("PASS nmea_gga_position_parser");
		else
			$display("FAIL nmea_gga_position_parser");
		$finish;
	end

endmodule
